// ===== rtl/stms_pkg.sv =====
// Package with shared types and constants for the sparse triplet multiply-subtract core.
package stms_pkg;

  localparam int AccumDepth = 4096;
  localparam int DenseDepth = 4096;
  localparam int AccumAw = $clog2(AccumDepth);
  localparam int DenseAw = $clog2(DenseDepth);

  typedef enum logic [1:0] {
    CMD_WRITE_C = 2'd0,
    CMD_WRITE_A = 2'd1,
    CMD_TRIPLET = 2'd2,
    CMD_READ_A  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ADDR_ERR = 2'd1,
    ST_TRIP_ERR = 2'd2
  } status_t;

  localparam logic [1:0] REG_ROWS_PER_STEP = 2'd0;
  localparam logic [1:0] REG_DENSE_COLS    = 2'd1;
  localparam logic [1:0] REG_TIME_STEPS    = 2'd2;
  localparam logic [1:0] REG_C_LEAD        = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted item
    logic div_start;  // start row division
    logic div_step;   // one restoring-division step
    logic chk1;       // first range check (last column step index)
    logic chk2;       // second range check (last-address products)
    logic chk3;       // address compare
    logic col_init;   // set up column walk
    logic rd;         // issue store reads for current column
    logic mul;        // register product
    logic wr;         // write back and advance column
    logic simple;     // perform write/read command
    logic finish;     // load output register
  } dp_cmd_t;

  typedef struct packed {
    logic    trip_ok;
    logic    last_col;
    logic    zero_cols;
    cmd_t    cmd;
  } dp_stat_t;

endpackage

// ===== rtl/stms_datapath.sv =====
// Datapath of the sparse triplet multiply-subtract core: stores, divider, multiplier.
module stms_datapath import stms_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  dp_cmd_t      cmd,
  output dp_stat_t     stat,
  input  logic [69:0]  in_data,
  input  logic [12:0]  rows_per_step,
  input  logic [6:0]   dense_cols,
  input  logic [6:0]   time_steps,
  input  logic [12:0]  c_lead,
  output logic [31:0]  res_value,
  output logic [1:0]   res_status
);

  logic [31:0] accum_mem [AccumDepth];
  logic [31:0] dense_mem [DenseDepth];

  cmd_t        op;
  logic [11:0] addr, row, col;
  logic signed [31:0] val;

  // Division: quotient and remainder of row by rows_per_step.
  logic [11:0] quot;
  logic [12:0] rem;
  logic [13:0] rem_shift;

  logic        bad;
  logic [13:0] s_last;
  logic [26:0] c_prod, a_prod;

  logic [26:0] c_base, a_base;   // addresses of current column
  logic [6:0]  k;
  logic signed [31:0] a_word, c_word;
  logic signed [63:0] prod;
  logic [31:0] rd_word;

  logic signed [47:0] prod_q;
  logic [31:0] sat;
  logic signed [48:0] diff_w;

  assign rem_shift = {rem, quot[11]};

  assign prod_q = prod[63:16];
  // |prod_q| fits well inside 48 bits; compute difference with saturation.
  assign diff_w = {{17{a_word[31]}}, a_word} - {prod_q[47], prod_q};
  always_comb begin
    if (diff_w > 49'sd2147483647) sat = 32'h7FFF_FFFF;
    else if (diff_w < -49'sd2147483648) sat = 32'h8000_0000;
    else sat = diff_w[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= cmd_t'(in_data[1:0]);
      addr <= in_data[13:2];
      row  <= in_data[25:14];
      col  <= in_data[37:26];
      val  <= in_data[69:38];
      bad  <= 1'b0;
    end
    if (cmd.div_start) begin
      quot    <= row;
      rem     <= '0;
      bad     <= (rows_per_step == '0) || ({1'b0, col} >= c_lead);
    end
    if (cmd.div_step) begin
      if (rem_shift >= {1'b0, rows_per_step}) begin
        rem  <= 13'(rem_shift - {1'b0, rows_per_step});
        quot <= {quot[10:0], 1'b1};
      end else begin
        rem  <= rem_shift[12:0];
        quot <= {quot[10:0], 1'b0};
      end
    end
    if (cmd.chk1) begin
      if (quot >= {5'd0, time_steps}) bad <= 1'b1;
      s_last <= 14'(quot[6:0]) * 14'(dense_cols) + 14'(dense_cols) - 14'd1;
    end
    if (cmd.chk2) begin
      c_prod <= s_last * c_lead;
      a_prod <= s_last * rows_per_step;
    end
    if (cmd.chk3) begin
      if (dense_cols != '0) begin
        if (({1'b0, c_prod} + 28'(col)) >= 28'(DenseDepth)) bad <= 1'b1;
        if (({1'b0, a_prod} + 28'(rem)) >= 28'(AccumDepth)) bad <= 1'b1;
      end
    end
    if (cmd.col_init) begin
      k      <= '0;
      c_base <= 27'(col) + 27'(s_last - 14'(dense_cols) + 14'd1) * c_lead;
      a_base <= 27'(rem) + 27'(s_last - 14'(dense_cols) + 14'd1) * rows_per_step;
    end
    if (cmd.rd) begin
      c_word <= dense_mem[c_base[DenseAw-1:0]];
      a_word <= accum_mem[a_base[AccumAw-1:0]];
    end
    if (cmd.mul) prod <= val * c_word;
    if (cmd.wr) begin
      accum_mem[a_base[AccumAw-1:0]] <= sat;
      a_base <= a_base + 27'(rows_per_step);
      c_base <= c_base + 27'(c_lead);
      k      <= k + 7'd1;
    end
    if (cmd.simple) begin
      unique case (op)
        CMD_WRITE_C: dense_mem[addr[DenseAw-1:0]] <= val;
        CMD_WRITE_A: accum_mem[addr[AccumAw-1:0]] <= val;
        CMD_READ_A:  rd_word <= accum_mem[addr[AccumAw-1:0]];
        default:     rd_word <= '0;
      endcase
    end
    if (cmd.finish) begin
      res_value  <= (op == CMD_READ_A) ? rd_word : '0;
      res_status <= (op == CMD_TRIPLET && bad) ? ST_TRIP_ERR : ST_OK;
    end
  end

  assign stat.trip_ok   = !bad;
  assign stat.last_col  = (k == dense_cols - 7'd1);
  assign stat.zero_cols = (dense_cols == '0);
  assign stat.cmd       = op;

  logic unused;
  assign unused = rst;

endmodule

// ===== rtl/stms_ctrl.sv =====
// Controller state machine of the sparse triplet multiply-subtract core.
module stms_ctrl import stms_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  output logic     in_ready,
  output logic     out_load,
  input  logic     out_busy,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_DIV, S_CHK1, S_CHK2, S_CHK3, S_INIT,
    S_RD, S_MUL, S_WR, S_SIMPLE, S_SIMPLE2, S_FIN
  } state_t;

  state_t     state;
  logic [3:0] cnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load      = in_fire;
    cmd.div_start = (state == S_DECODE);
    cmd.div_step  = (state == S_DIV);
    cmd.chk1      = (state == S_CHK1);
    cmd.chk2      = (state == S_CHK2);
    cmd.chk3      = (state == S_CHK3);
    cmd.col_init  = (state == S_INIT);
    cmd.rd        = (state == S_RD);
    cmd.mul       = (state == S_MUL);
    cmd.wr        = (state == S_WR);
    cmd.simple    = (state == S_SIMPLE);
    cmd.finish    = (state == S_FIN) && !out_busy;
  end
  assign out_load = cmd.finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE:   if (in_fire) state <= S_DECODE;
        S_DECODE: begin
          cnt   <= '0;
          state <= (stat.cmd == CMD_TRIPLET) ? S_DIV : S_SIMPLE;
        end
        S_DIV: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd11) state <= S_CHK1;
        end
        S_CHK1:   state <= S_CHK2;
        S_CHK2:   state <= S_CHK3;
        S_CHK3:   state <= S_INIT;
        S_INIT:   state <= (!stat.trip_ok || stat.zero_cols) ? S_FIN : S_RD;
        S_RD:     state <= S_MUL;
        S_MUL:    state <= S_WR;
        S_WR:     state <= stat.last_col ? S_FIN : S_RD;
        S_SIMPLE: state <= S_SIMPLE2;
        S_SIMPLE2: state <= S_FIN;
        S_FIN:    if (!out_busy) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/sparse_triplet_mult_subtract_core.sv =====
// Top level of the sparse triplet multiply-subtract core.
// The core holds a 4096-word dense store C and a 4096-word accumulator store A
// of Q16.16 words and takes one command per transfer on the slave stream:
// write a C word, write an A word, apply a sparse triplet, or read an A word.
// Each command gives exactly one result transfer with a read value and a status.
// A triplet first runs its setup (a 12-step restoring division of the row by
// rows_per_step and the range checks), then, for each dense column, the read,
// multiply and write-back of one accumulator word.
// One item is in work at a time; the result register lets the next item be
// taken while the previous result waits. Configuration must be written only
// when idle; the core itself does not enforce this.
module sparse_triplet_mult_subtract_core import stms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: command[1:0], address[13:2], row_index[25:14], col_index[37:26],
  // value[69:38], zero fill to 72 bits.
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: read_value[31:0], status[33:32], zero fill to 40 bits.
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  logic [12:0] rows_per_step, c_lead;
  logic [6:0]  dense_cols, time_steps;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_per_step <= 13'd1;
      dense_cols    <= 7'd1;
      time_steps    <= 7'd1;
      c_lead        <= 13'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROWS_PER_STEP: rows_per_step <= cfg_data;
        REG_DENSE_COLS:    dense_cols    <= cfg_data[6:0];
        REG_TIME_STEPS:    time_steps    <= cfg_data[6:0];
        REG_C_LEAD:        c_lead        <= cfg_data;
        default: ;
      endcase
    end
  end

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_fire, out_load;
  logic [31:0] res_value;
  logic [1:0]  res_status;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  stms_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_ready(s_axis_tready), .out_load,
    .out_busy(m_axis_tvalid && !m_axis_tready), .cmd, .stat
  );

  stms_datapath u_dp (
    .clk, .rst, .cmd, .stat, .in_data(s_axis_tdata[69:0]),
    .rows_per_step, .dense_cols, .time_steps, .c_lead, .res_value, .res_status
  );

  // The zero fill bits of the input transfer carry nothing.
  logic unused_tdata;
  assign unused_tdata = ^s_axis_tdata[71:70];

  // The datapath loads its result register on out_load; out_load is registered in pend, and pend then sets valid.
  logic pend;
  always_ff @(posedge clk) begin
    if (rst) begin
      pend          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      pend <= out_load;
      if (pend) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end
  assign m_axis_tdata = {6'd0, res_status, res_value};

  a_one_output: assert property (@(posedge clk) disable iff (rst)
    out_load |=> !out_load) else $error("result loaded twice");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !s_axis_tready) else $error("accept during finish");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> res_status != 2'd3) else $error("bad status");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the sparse triplet multiply-subtract core.
module tb_top;
  import stms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Predicts the core's results and checks each result transfer in order.
  class stms_scoreboard;
    logic [31:0] acc_mem [AccumDepth];
    logic [31:0] dense_mem [DenseDepth];
    logic [12:0] rows_per_step;
    logic [6:0] dense_cols;
    logic [6:0] time_steps;
    logic [12:0] c_lead;
    logic [31:0] exp_value_q[$];
    status_t exp_status_q[$];
    int errors;

    function void reset_state();
      rows_per_step = 1;
      dense_cols = 1;
      time_steps = 1;
      c_lead = 1;
      errors = 0;
    endfunction

    function void note_config(logic [1:0] idx, logic [12:0] data);
      case (idx)
        REG_ROWS_PER_STEP: rows_per_step = data;
        REG_DENSE_COLS: dense_cols = data[6:0];
        REG_TIME_STEPS: time_steps = data[6:0];
        default: c_lead = data;
      endcase
    endfunction

    // Range check of a triplet, without touching the stores.
    function status_t triplet_status(int row, int col);
      int local_row, step, s;
      if (rows_per_step == 0 || col >= c_lead) return ST_TRIP_ERR;
      local_row = row % rows_per_step;
      step = row / rows_per_step;
      if (step >= time_steps) return ST_TRIP_ERR;
      if (dense_cols == 0) return ST_OK;
      s = (dense_cols - 1) + step * dense_cols;
      if (col + s * c_lead >= DenseDepth) return ST_TRIP_ERR;
      if (local_row + s * rows_per_step >= AccumDepth) return ST_TRIP_ERR;
      return ST_OK;
    endfunction

    function void apply_triplet(int row, int col, logic [31:0] val);
      int local_row, step, s, ic, ia;
      longint prod, diff;
      local_row = row % rows_per_step;
      step = row / rows_per_step;
      for (int k = 0; k < dense_cols; k++) begin
        s = k + step * dense_cols;
        ic = col + s * c_lead;
        ia = local_row + s * rows_per_step;
        // Arithmetic shift floors the Q32.32 product back to Q16.16.
        prod = (longint'($signed(val)) * longint'($signed(dense_mem[ic]))) >>> 16;
        diff = longint'($signed(acc_mem[ia])) - prod;
        if (diff > 64'sh7FFFFFFF) diff = 64'sh7FFFFFFF;
        if (diff < -64'sh80000000) diff = -64'sh80000000;
        acc_mem[ia] = diff[31:0];
      end
    endfunction

    function void note_input(cmd_t cmd, int addr, int row, int col, logic [31:0] val);
      logic [31:0] rd;
      status_t st;
      rd = '0;
      st = ST_OK;
      case (cmd)
        CMD_WRITE_C: dense_mem[addr] = val;
        CMD_WRITE_A: acc_mem[addr] = val;
        CMD_TRIPLET: begin
          st = triplet_status(row, col);
          if (st == ST_OK) apply_triplet(row, col, val);
        end
        default: rd = acc_mem[addr];
      endcase
      exp_value_q.push_back(rd);
      exp_status_q.push_back(st);
    endfunction

    function void check_result(logic [39:0] data);
      if (exp_value_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, data);
        errors++;
        return;
      end
      if (data[31:0] !== exp_value_q[0]) begin
        $display("%0t: read_value expected %h actual %h", $time, exp_value_q[0], data[31:0]);
        errors++;
      end
      if (data[33:32] !== exp_status_q[0]) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_status_q[0], data[33:32]);
        errors++;
      end
      void'(exp_value_q.pop_front());
      void'(exp_status_q.pop_front());
    endfunction

    function int pending();
      return exp_value_q.size();
    endfunction
  endclass

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  // tdata: command, address, row_index, col_index, value, zero fill.
  logic [71:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  // tdata: read_value, status, zero fill.
  logic [39:0] m_axis_tdata;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [12:0] cfg_data;

  int send_idle_pct, recv_idle_pct;
  stms_scoreboard sb;

  sparse_triplet_mult_subtract_core u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("tb_top: errors");
    $finish;
  end

  // The receiver stalls at random; every accepted result transfer is checked.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Writes one configuration register and mirrors it in the scoreboard.
  task automatic write_reg(logic [1:0] idx, int data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= 13'(data);
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, 13'(data));
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_config(int rps, int dc, int ts, int cl);
    write_reg(REG_ROWS_PER_STEP, rps);
    write_reg(REG_DENSE_COLS, dc);
    write_reg(REG_TIME_STEPS, ts);
    write_reg(REG_C_LEAD, cl);
  endtask

  // Sends one command transfer, with an optional random gap before it.
  // Valid stays high after the transfer until the next gap or drain().
  task automatic send_cmd(cmd_t cmd, int addr, int row, int col, logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {2'b0, val, col[11:0], row[11:0], addr[11:0], cmd};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(cmd, addr, row, col, val);
  endtask

  // Waits until every result is back, then lets the core settle.
  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 0;
    while (sb.pending() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (250) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(32'h3FFFF);
      3: return -$urandom_range(32'h3FFFF);
      default: return $urandom;
    endcase
  endfunction

  // Fills the stores a triplet under the current settings can touch, so no
  // triplet or read ever meets an unwritten word.
  task automatic prefill(int acc_n, int dense_n);
    for (int a = 0; a < dense_n; a++) send_cmd(CMD_WRITE_C, a, 0, 0, rand_word());
    for (int a = 0; a < acc_n; a++) send_cmd(CMD_WRITE_A, a, 0, 0, rand_word());
  endtask

  // Random mix of commands; reads and triplets stay within the written area.
  task automatic random_phase(int n, int acc_n);
    int row, col, addr;
    for (int i = 0; i < n; i++) begin
      addr = $urandom_range(acc_n - 1);
      case ($urandom_range(9))
        0: send_cmd(CMD_WRITE_C, $urandom_range(4095), 0, 0, rand_word());
        1: send_cmd(CMD_WRITE_A, addr, 0, 0, rand_word());
        2, 3: send_cmd(CMD_READ_A, acc_n > 1 ? addr : 0, 0, 0, 0);
        default: begin
          row = ($urandom_range(9) == 0) ? $urandom_range(4095)
                                         : $urandom_range(sb.rows_per_step * sb.time_steps);
          col = ($urandom_range(9) == 0) ? $urandom_range(4095)
                                         : $urandom_range(sb.c_lead);
          if (row > 4095) row = 4095;
          if (sb.triplet_status(row, col) == ST_OK || $urandom_range(3) == 0)
            send_cmd(CMD_TRIPLET, $urandom_range(4095), row, col, rand_word());
        end
      endcase
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 22;
    recv_idle_pct = 57;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part under reset settings: extremes, saturation, all commands.
    send_cmd(CMD_WRITE_C, 0, 0, 0, 32'h7FFFFFFF);
    send_cmd(CMD_WRITE_A, 0, 0, 0, 32'h80000000);
    send_cmd(CMD_WRITE_A, 4095, 0, 0, 32'hFFFFFFFF);
    send_cmd(CMD_WRITE_C, 4095, 0, 0, 32'h00010000);
    send_cmd(CMD_TRIPLET, 4095, 0, 0, 32'h7FFFFFFF);  // saturates low
    send_cmd(CMD_READ_A, 0, 0, 0, 0);
    send_cmd(CMD_TRIPLET, 0, 0, 0, 32'h80000000);     // saturates high
    send_cmd(CMD_READ_A, 0, 0, 0, 0);
    send_cmd(CMD_TRIPLET, 0, 1, 0, 32'h1);           // step past time_steps
    send_cmd(CMD_TRIPLET, 0, 0, 1, 32'h1);           // column not below c_lead
    send_cmd(CMD_TRIPLET, 0, 4095, 4095, 32'hFFFFFFFF);
    send_cmd(CMD_WRITE_C, 0, 0, 0, 32'hFFFF8000);
    send_cmd(CMD_TRIPLET, 0, 0, 0, 32'h00000003);    // negative product floors
    send_cmd(CMD_READ_A, 4095, 0, 0, 0);
    send_cmd(CMD_READ_A, 0, 0, 0, 0);
    drain();

    // Zero rows per step and zero dense columns.
    set_config(0, 1, 1, 1);
    send_cmd(CMD_TRIPLET, 0, 0, 0, 32'h10000);
    drain();
    write_reg(REG_ROWS_PER_STEP, 1);
    write_reg(REG_DENSE_COLS, 0);
    send_cmd(CMD_TRIPLET, 0, 0, 0, 32'h10000);
    send_cmd(CMD_READ_A, 0, 0, 0, 0);
    drain();

    // Largest settings: the address checks fail at once, then a full
    // 64-column triplet whose last C word sits at 4032.
    set_config(4096, 64, 64, 4096);
    send_cmd(CMD_TRIPLET, 0, 0, 0, 32'h10000);
    drain();
    set_config(1, 64, 64, 64);
    for (int k = 0; k < 64; k++) begin
      send_cmd(CMD_WRITE_C, k * 64, 0, 0, rand_word());
      send_cmd(CMD_WRITE_A, k, 0, 0, rand_word());
    end
    send_cmd(CMD_TRIPLET, 0, 0, 0, 32'h10000);
    drain();

    // Random phases over several settings and idle patterns.
    set_config(3, 2, 4, 5);
    prefill(3 * 8, 5 * 8);
    random_phase(250, 24);
    drain();
    send_idle_pct = 57;
    recv_idle_pct = 22;
    set_config(2, 64, 2, 2);
    prefill(2 * 128, 2 * 128);
    random_phase(40, 256);
    drain();
    set_config(7, 4, 8, 3);
    random_phase(200, 224);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(1, 1, 64, 1);
    random_phase(250, 64);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/stms_pkg.sv
rtl/stms_datapath.sv
rtl/stms_ctrl.sv
rtl/sparse_triplet_mult_subtract_core.sv
test/tb_top.sv
